### rtl/dpsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_pkg
// Shared widths, reset values, beat types and codes for the dual pedal
// sensor conditioner.
// ----------------------------------------------------------------------------
package dpsc_pkg;

    localparam int SAMPLE_BITS   = 12;
    localparam int FRACTION_BITS = 16;
    localparam int OUT_BITS      = FRACTION_BITS + 1;

    localparam int A_MIN_RESET = 1550;
    localparam int A_MAX_RESET = 4095;
    localparam int B_MIN_RESET = 1750;
    localparam int B_MAX_RESET = 3289;

    localparam logic [OUT_BITS-1:0] FRAC_ONE = OUT_BITS'(1) << FRACTION_BITS;

    typedef enum logic [1:0] {
        CFG_A_MIN = 2'd0,
        CFG_A_MAX = 2'd1,
        CFG_B_MIN = 2'd2,
        CFG_B_MAX = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        NS_IDLE,
        NS_SMOOTH,
        NS_PREP,
        NS_NORM,
        NS_HOLD
    } norm_state_t;

    typedef struct packed {
        logic idle;
        logic hold;
    } norm_status_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_a;
        logic [SAMPLE_BITS-1:0] sample_b;
    } sample_beat_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] pedal_level;
        logic [OUT_BITS-1:0] sensor_disagreement;
    } result_beat_t;

endpackage

### rtl/dpsc_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_norm
// One sensor track: bit-serial divide by five for the smoothing filter, then
// bit-serial restoring division that scales the smoothed value into a
// fraction of the configured min..max span.
// ----------------------------------------------------------------------------
module dpsc_norm
    import dpsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic                   take,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [SAMPLE_BITS-1:0] lo,
    input  logic [SAMPLE_BITS-1:0] hi,
    output norm_status_t           status,
    output logic [OUT_BITS-1:0]    frac
);

    localparam int SUM_BITS  = SAMPLE_BITS + 3;
    localparam int STEPS_MAX = (SUM_BITS > FRACTION_BITS) ? SUM_BITS : FRACTION_BITS;
    localparam int CNT_BITS  = $clog2(STEPS_MAX);
    localparam logic [CNT_BITS-1:0] SMOOTH_LAST = CNT_BITS'(SUM_BITS - 1);
    localparam logic [CNT_BITS-1:0] NORM_LAST   = CNT_BITS'(FRACTION_BITS - 1);

    norm_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]    cnt_reg, cnt_next;
    logic [SAMPLE_BITS-1:0] smoothed_reg, smoothed_next;
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [2:0]             rem5_reg, rem5_next;
    logic [SAMPLE_BITS-1:0] rem_reg, rem_next;
    logic [SAMPLE_BITS-1:0] range_reg, range_next;
    logic [OUT_BITS-1:0]    frac_reg, frac_next;

    logic [3:0]             cand5;
    logic                   ge5;
    logic [SAMPLE_BITS:0]   dbl;
    logic                   ge_rng;

    // one quotient bit of the divide by five
    assign cand5 = {rem5_reg, sum_reg[SUM_BITS-1]};
    assign ge5   = (cand5 >= 4'd5);

    // one quotient bit of the span division
    assign dbl    = {rem_reg, 1'b0};
    assign ge_rng = (dbl >= {1'b0, range_reg});

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            NS_IDLE:
            begin
                if (start)
                    state_next = NS_SMOOTH;
            end
            NS_SMOOTH:
            begin
                if (cnt_reg == SMOOTH_LAST)
                    state_next = NS_PREP;
            end
            NS_PREP:
            begin
                if (hi <= lo || smoothed_reg <= lo || smoothed_reg >= hi)
                    state_next = NS_HOLD;
                else
                    state_next = NS_NORM;
            end
            NS_NORM:
            begin
                if (cnt_reg == NORM_LAST)
                    state_next = NS_HOLD;
            end
            NS_HOLD:
            begin
                if (take)
                    state_next = NS_IDLE;
            end
            default: state_next = NS_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next      = cnt_reg;
        smoothed_next = smoothed_reg;
        sum_next      = sum_reg;
        rem5_next     = rem5_reg;
        rem_next      = rem_reg;
        range_next    = range_reg;
        frac_next     = frac_reg;
        case (state_reg)
            NS_IDLE:
            begin
                cnt_next  = '0;
                rem5_next = '0;
                // 2*sample + 3*old
                sum_next  = {2'b00, sample, 1'b0}
                          + {2'b00, smoothed_reg, 1'b0}
                          + {3'b000, smoothed_reg};
            end
            NS_SMOOTH:
            begin
                cnt_next  = cnt_reg + 1'b1;
                rem5_next = ge5 ? 3'(cand5 - 4'd5) : cand5[2:0];
                sum_next  = {sum_reg[SUM_BITS-2:0], ge5};
                if (cnt_reg == SMOOTH_LAST)
                    smoothed_next = sum_next[SAMPLE_BITS-1:0];
            end
            NS_PREP:
            begin
                cnt_next   = '0;
                range_next = hi - lo;
                rem_next   = smoothed_reg - lo;
                if (hi <= lo || smoothed_reg <= lo)
                    frac_next = '0;
                else if (smoothed_reg >= hi)
                    frac_next = FRAC_ONE;
                else
                    frac_next = '0;
            end
            NS_NORM:
            begin
                cnt_next  = cnt_reg + 1'b1;
                rem_next  = ge_rng ? SAMPLE_BITS'(dbl - {1'b0, range_reg})
                                   : dbl[SAMPLE_BITS-1:0];
                frac_next = {frac_reg[OUT_BITS-2:0], ge_rng};
            end
            NS_HOLD:
            begin
                cnt_next = '0;
            end
            default:
            begin
                cnt_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= NS_IDLE;
            cnt_reg      <= '0;
            smoothed_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            smoothed_reg <= smoothed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg   <= sum_next;
        rem5_reg  <= rem5_next;
        rem_reg   <= rem_next;
        range_reg <= range_next;
        frac_reg  <= frac_next;
    end

    assign status.idle = (state_reg == NS_IDLE);
    assign status.hold = (state_reg == NS_HOLD);
    assign frac        = frac_reg;

endmodule

### rtl/dual_pedal_sensor_conditioner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_pedal_sensor_conditioner_top
// Smooths a pair of pedal sensor samples, scales each into a Q16 fraction of
// its calibrated span and reports the average and the mismatch of the two.
// ----------------------------------------------------------------------------
// A sample beat passes the bit-serial divide by five (15 steps), then 16 steps
//   of the span division, one bit per cycle in each track; the span division
//   is skipped in a track whose fraction clamps to zero or full scale. One
//   sample beat is taken at a time, the next once both tracks have handed
//   on their results; a held result does not block the next sample
// reset: calibration registers take their default spans, filter state clears
module dual_pedal_sensor_conditioner_top
    import dpsc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   smp_valid,
    output logic                   smp_stall,
    input  sample_beat_t           smp_data,
    output logic                   res_valid,
    input  logic                   res_stall,
    output result_beat_t           res_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  cfg_index_t             cfg_index,
    input  logic [SAMPLE_BITS-1:0] cfg_data
);

    logic [SAMPLE_BITS-1:0] a_min_reg, a_max_reg, b_min_reg, b_max_reg;
    logic                   res_valid_reg, res_valid_next;
    result_beat_t           res_data_reg, res_data_next;

    norm_status_t           stat_a, stat_b;
    logic [OUT_BITS-1:0]    frac_a, frac_b;
    logic                   start, take;
    logic [OUT_BITS:0]      frac_sum;

    assign cfg_ready = 1'b1;
    assign smp_stall = !(stat_a.idle && stat_b.idle);
    assign start     = smp_valid && !smp_stall;
    assign take      = stat_a.hold && stat_b.hold && (!res_valid_reg || !res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_min_reg <= SAMPLE_BITS'(A_MIN_RESET);
            a_max_reg <= SAMPLE_BITS'(A_MAX_RESET);
            b_min_reg <= SAMPLE_BITS'(B_MIN_RESET);
            b_max_reg <= SAMPLE_BITS'(B_MAX_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_A_MIN: a_min_reg <= cfg_data;
                CFG_A_MAX: a_max_reg <= cfg_data;
                CFG_B_MIN: b_min_reg <= cfg_data;
                CFG_B_MAX: b_max_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    dpsc_norm u_norm_a (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .take   (take),
        .sample (smp_data.sample_a),
        .lo     (a_min_reg),
        .hi     (a_max_reg),
        .status (stat_a),
        .frac   (frac_a)
    );

    dpsc_norm u_norm_b (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .take   (take),
        .sample (smp_data.sample_b),
        .lo     (b_min_reg),
        .hi     (b_max_reg),
        .status (stat_b),
        .frac   (frac_b)
    );

    assign frac_sum = {1'b0, frac_a} + {1'b0, frac_b};

    always_comb
    begin
        res_valid_next = res_valid_reg && res_stall;
        res_data_next  = res_data_reg;
        if (take)
        begin
            res_valid_next                    = 1'b1;
            res_data_next.pedal_level         = frac_sum[OUT_BITS:1];
            res_data_next.sensor_disagreement = (frac_a >= frac_b) ? (frac_a - frac_b)
                                                                   : (frac_b - frac_a);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        res_data_reg <= res_data_next;
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

### rtl/dpsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpsc_checker
// Port-level checks for the dual pedal sensor conditioner, bound to the top.
// ----------------------------------------------------------------------------
module dpsc_checker
    import dpsc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   smp_valid,
    input logic                   smp_stall,
    input logic                   res_valid,
    input logic                   res_stall,
    input result_beat_t           res_data
);

    // a held result beat keeps its payload
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result beat changed while stalled");

    // one sample at a time: the block is busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && !smp_stall |=> smp_stall)
        else $error("sample accepted while previous one in flight");

    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res_data.pedal_level <= FRAC_ONE)
                   && (res_data.sensor_disagreement <= FRAC_ONE))
        else $error("result above full scale");

    // average of two fractions is never below half their difference
    a_level_vs_diff: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.pedal_level >= (res_data.sensor_disagreement >> 1))
        else $error("pedal level inconsistent with disagreement");

endmodule

bind dual_pedal_sensor_conditioner_top dpsc_checker u_dpsc_checker (.*);
